FILE: sv/cfcp_pkg.sv
// Package for the class file constant pool checker.
// Holds status codes, field widths, the magic word and the verdict struct.
// No dependencies.
package cfcp_pkg;

    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 16;
    localparam int OUT_OFF_W = 24;

    localparam logic [STATUS_W-1:0] ST_VALID = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MAGIC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TAG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 3'd4;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;

    // Constant pool tags that the walker accepts.
    localparam logic [7:0] TAG_UTF8      = 8'd1;
    localparam logic [7:0] TAG_INTEGER   = 8'd3;
    localparam logic [7:0] TAG_FLOAT     = 8'd4;
    localparam logic [7:0] TAG_LONG      = 8'd5;
    localparam logic [7:0] TAG_DOUBLE    = 8'd6;
    localparam logic [7:0] TAG_CLASS     = 8'd7;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_FIELDREF  = 8'd9;
    localparam logic [7:0] TAG_METHODREF = 8'd10;
    localparam logic [7:0] TAG_IMETHREF  = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

    typedef struct packed {
        logic                 valid;
        logic [STATUS_W-1:0]  status;
        logic [ENTRY_W-1:0]   entry;
        logic [OUT_OFF_W-1:0] offset;
    } t_verdict;

    // Expected magic byte at position idx, most significant byte first.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = MAGIC_WORD[31:24];
            2'd1:    b = MAGIC_WORD[23:16];
            2'd2:    b = MAGIC_WORD[15:8];
            default: b = MAGIC_WORD[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: sv/class_file_constant_pool_checker_core.sv
// Top level of the class file constant pool checker: input register, parser and
// result register. Depends on cfcp_pkg and cfcp_parser.
//
// The block takes one byte of a class file per cycle, with a flag on the last
// byte, and returns at most one verdict per file: valid, bad magic, empty pool,
// bad tag or truncated, with the pool entry and the byte offset where it was
// reached. A byte passes through an input register and the parser into the
// result register; the verdict is registered there from the byte that decided
// it. One byte is accepted every cycle; the input stalls only while a verdict
// waits in the result register and the output side stalls. Bytes after a
// verdict are consumed silently up to the final byte, after which the next
// file starts from a clean state. The byte offset saturates at
// 2^OFFSET_BITS - 1 and its low 24 bits are reported.
module class_file_constant_pool_checker_core import cfcp_pkg::*; #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_final_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ENTRY_W-1:0]   o_entry_reached,
    output logic [OUT_OFF_W-1:0] o_byte_offset
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [ENTRY_W-1:0]   r_entry;
    logic [OUT_OFF_W-1:0] r_offset;

    logic     w_advance;
    logic     w_fire;
    logic     w_in_xfer;
    t_verdict w_verdict;

    // The pipeline moves whenever the result register is free or being drained.
    assign w_advance = !(r_out_valid && i_stall);
    assign w_fire    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_in_xfer = i_valid && !o_stall;

    cfcp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_data_byte  (r_in_byte),
        .i_final_byte (r_in_last),
        .o_verdict    (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_verdict.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_verdict.valid) begin
            r_status <= w_verdict.status;
            r_entry  <= w_verdict.entry;
            r_offset <= w_verdict.offset;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_reached = r_entry;
    assign o_byte_offset   = r_offset;

endmodule

FILE: sv/cfcp_parser.sv
// Byte-level parser state machine for the class file constant pool checker.
// Updates phase and counters for one byte per fire and reports the verdict.
// Depends on cfcp_pkg.
module cfcp_parser import cfcp_pkg::*; #(
    parameter int OFFSET_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_verdict   o_verdict
);

    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_VERSION   = 4'd1,
        PH_COUNT_HI  = 4'd2,
        PH_COUNT_LO  = 4'd3,
        PH_TAG       = 4'd4,
        PH_SKIP      = 4'd5,
        PH_SKIP_WIDE = 4'd6,
        PH_ULEN_HI   = 4'd7,
        PH_ULEN_LO   = 4'd8,
        PH_DRAIN     = 4'd9
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    t_phase                 r_phase, n_phase;
    logic [15:0]            r_cnt, n_cnt;
    logic [15:0]            r_pool, n_pool;
    logic [15:0]            r_entry, n_entry;
    logic [7:0]             r_hi, n_hi;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic                   r_given, n_given;

    logic [OFFSET_BITS-1:0]           w_off_inc;
    logic [OFFSET_BITS+OUT_OFF_W-1:0] w_off_ext;
    logic [15:0]                      w_cnt_dec;
    logic [16:0]                      w_adv_sum;
    logic                             w_pool_end;
    logic [15:0]                      w_ulen;
    t_verdict                         w_verdict;

    assign w_off_inc  = (r_off != OFF_MAX) ? r_off + 1'b1 : r_off;
    assign w_off_ext  = {{OUT_OFF_W{1'b0}}, w_off_inc};
    assign w_cnt_dec  = (r_cnt != 16'd0) ? r_cnt - 16'd1 : r_cnt;
    assign w_adv_sum  = {1'b0, r_entry} + ((r_phase == PH_SKIP_WIDE) ? 17'd2 : 17'd1);
    assign w_pool_end = (w_adv_sum >= {1'b0, r_pool});
    assign w_ulen     = {r_hi, i_data_byte};

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_pool    = r_pool;
        n_entry   = r_entry;
        n_hi      = r_hi;
        n_off     = w_off_inc;
        n_given   = r_given;
        w_verdict = '{valid: 1'b0, status: ST_VALID, entry: '0,
                      offset: w_off_ext[OUT_OFF_W-1:0]};

        unique case (r_phase)
            PH_MAGIC: begin
                if (i_data_byte != magic_byte(r_cnt[1:0])) begin
                    w_verdict.valid  = 1'b1;
                    w_verdict.status = ST_MAGIC;
                end else if (r_cnt >= 16'd3) begin
                    n_cnt   = '0;
                    n_phase = PH_VERSION;
                end else begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            PH_VERSION: begin
                if (r_cnt >= 16'd3) begin
                    n_cnt   = '0;
                    n_phase = PH_COUNT_HI;
                end else begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            PH_COUNT_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
                n_pool = w_ulen;
                if (w_ulen == 16'd0) begin
                    w_verdict.valid  = 1'b1;
                    w_verdict.status = ST_EMPTY;
                end else if (w_ulen == 16'd1) begin
                    // A count of one means an empty but legal pool.
                    w_verdict.valid  = 1'b1;
                    w_verdict.status = ST_VALID;
                    w_verdict.entry  = 16'd1;
                end else begin
                    n_entry = 16'd1;
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                unique case (i_data_byte)
                    TAG_UTF8: n_phase = PH_ULEN_HI;
                    TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
                    TAG_IMETHREF, TAG_NAMETYPE: begin
                        n_cnt   = 16'd4;
                        n_phase = PH_SKIP;
                    end
                    TAG_LONG, TAG_DOUBLE: begin
                        n_cnt   = 16'd8;
                        n_phase = PH_SKIP_WIDE;
                    end
                    TAG_CLASS, TAG_STRING: begin
                        n_cnt   = 16'd2;
                        n_phase = PH_SKIP;
                    end
                    default: begin
                        w_verdict.valid  = 1'b1;
                        w_verdict.status = ST_TAG;
                        w_verdict.entry  = r_entry;
                    end
                endcase
            end
            PH_SKIP, PH_SKIP_WIDE: begin
                n_cnt = w_cnt_dec;
                if (w_cnt_dec == 16'd0) begin
                    if (w_pool_end) begin
                        w_verdict.valid  = 1'b1;
                        w_verdict.status = ST_VALID;
                        w_verdict.entry  = r_pool;
                    end else begin
                        n_entry = w_adv_sum[15:0];
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_ULEN_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_ULEN_LO;
            end
            PH_ULEN_LO: begin
                n_cnt = w_ulen;
                if (w_ulen != 16'd0) begin
                    n_phase = PH_SKIP;
                end else if (w_pool_end) begin
                    w_verdict.valid  = 1'b1;
                    w_verdict.status = ST_VALID;
                    w_verdict.entry  = r_pool;
                end else begin
                    n_entry = w_adv_sum[15:0];
                    n_phase = PH_TAG;
                end
            end
            default: ;
        endcase

        if (w_verdict.valid) begin
            n_given = 1'b1;
            n_phase = PH_DRAIN;
        end

        if (i_final_byte) begin
            // Data ran out before any verdict: report truncation.
            if (!n_given) begin
                w_verdict.valid  = 1'b1;
                w_verdict.status = ST_TRUNC;
                w_verdict.entry  = (n_phase == PH_TAG || n_phase == PH_SKIP ||
                                    n_phase == PH_SKIP_WIDE || n_phase == PH_ULEN_HI ||
                                    n_phase == PH_ULEN_LO) ? n_entry : 16'd0;
            end
            n_phase = PH_MAGIC;
            n_cnt   = '0;
            n_pool  = '0;
            n_entry = 16'd1;
            n_hi    = '0;
            n_off   = '0;
            n_given = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_cnt   <= '0;
            r_pool  <= '0;
            r_entry <= 16'd1;
            r_hi    <= '0;
            r_off   <= '0;
            r_given <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pool  <= n_pool;
            r_entry <= n_entry;
            r_hi    <= n_hi;
            r_off   <= n_off;
            r_given <= n_given;
        end
    end

    assign o_verdict = w_verdict;

endmodule

FILE: sv/cfcp_checker.sv
// Port-level assertions for the class file constant pool checker core.
// Depends on cfcp_pkg; bound to class_file_constant_pool_checker_core below.
module cfcp_checker import cfcp_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic [7:0]           i_data_byte,
    input logic                 i_final_byte,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [STATUS_W-1:0]  o_status,
    input logic [ENTRY_W-1:0]   o_entry_reached,
    input logic [OUT_OFF_W-1:0] o_byte_offset
);

    // With no verdict pending, the input side must never be held off.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while result register is empty");

    // A stalled verdict holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) &&
            $stable(o_entry_reached) && $stable(o_byte_offset))
        else $error("stalled verdict changed");

    // A magic mismatch is found within the first four bytes, before the pool.
    a_magic_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_MAGIC |->
            o_entry_reached == 16'd0 && o_byte_offset >= 24'd1 &&
            o_byte_offset <= 24'd4)
        else $error("bad magic verdict with wrong entry or offset");

    // An empty pool is known exactly at the low byte of the count.
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |->
            o_entry_reached == 16'd0 && o_byte_offset == 24'd10)
        else $error("empty pool verdict with wrong entry or offset");

endmodule

bind class_file_constant_pool_checker_core cfcp_checker u_cfcp_checker (.*);
